[src/ddar_pkg.sv]
// Package: shared constants, types and command/status structs for the raycaster.
package ddar_pkg;

    localparam int MAP_SIZE      = 64;
    localparam int SCREEN_HEIGHT = 1024;
    localparam int FRAC_BITS     = 16;
    localparam int MAP_W         = $clog2(MAP_SIZE);
    localparam int MAP_DEPTH     = MAP_SIZE * MAP_SIZE;
    localparam int MAP_AW        = $clog2(MAP_DEPTH);
    localparam int MAX_STEPS     = 2 * MAP_SIZE + 2;
    localparam int STEP_W        = $clog2(MAX_STEPS + 1);

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [23:0] MAX24 = 24'hFF_FFFF;
    localparam logic [15:0] MAX16 = 16'hFFFF;

    localparam logic [2:0] REG_POS_X  = 3'd0;
    localparam logic [2:0] REG_POS_Y  = 3'd1;
    localparam logic [2:0] REG_DIR_X  = 3'd2;
    localparam logic [2:0] REG_DIR_Y  = 3'd3;
    localparam logic [2:0] REG_PLN_X  = 3'd4;
    localparam logic [2:0] REG_PLN_Y  = 3'd5;
    localparam logic [2:0] REG_TEX_W  = 3'd6;
    localparam logic [2:0] REG_TEX_H  = 3'd7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // Divider operand selects.
    typedef enum logic [1:0] {
        DIV_DX = 2'd0,
        DIV_DY = 2'd1,
        DIV_H  = 2'd2,
        DIV_TS = 2'd3
    } t_div_sel;

    typedef struct packed {
        logic     load;       // capture input word
        logic     ray;        // form ray direction
        logic     div_start;
        t_div_sel div_sel;
        logic     div_take;   // store divider result
        logic     side_mul;   // side distance products
        logic     walk_step;  // one DDA step
        logic     fin_perp;   // perp distance and face
        logic     fin_wall;   // wall hit product
        logic     fin_tex;    // texture column, draw rows
        logic     out_load;
        logic     out_nohit;
    } t_cmd;

    typedef struct packed {
        logic is_write;
        logic div_done;
        logic walk_hit;
        logic walk_exit;
        logic steps_done;
    } t_sts;

endpackage

[src/ddar_divider.sv]
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module ddar_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    import ddar_pkg::*;

    logic [63:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_trial;
    logic [32:0] n_shift;

    assign n_shift = {r_rem[31:0], r_quo[63]};
    assign n_trial = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!n_trial[32]) begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

[src/ddar_datapath.sv]
// Datapath: registers, map memory, ray setup, DDA walker and column results.
module ddar_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ddar_pkg::t_cmd         i_cmd,
    output ddar_pkg::t_sts         o_sts,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [21:0]            i_cfg_data,
    input  logic                   i_opcode,
    input  logic [5:0]             i_cell_x,
    input  logic [5:0]             i_cell_y,
    input  logic                   i_cell_is_wall,
    input  logic signed [17:0]     i_camera_offset,
    output logic [31:0]            o_perp_distance,
    output logic [1:0]             o_hit_face,
    output logic [5:0]             o_hit_cell_x,
    output logic [5:0]             o_hit_cell_y,
    output logic [15:0]            o_line_height,
    output logic [9:0]             o_draw_start,
    output logic [9:0]             o_draw_end,
    output logic [7:0]             o_tex_column,
    output logic [23:0]            o_tex_step,
    output logic [23:0]            o_tex_start_pos,
    output logic                   o_no_hit
);
    import ddar_pkg::*;

    // Configuration.
    logic [21:0]        r_pos_x, r_pos_y;
    logic signed [18:0] r_dir_x, r_dir_y, r_pln_x, r_pln_y;
    logic [8:0]         r_tex_w, r_tex_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= 22'd2129920;
            r_pos_y <= 22'd2129920;
            r_dir_x <= 19'sd0;
            r_dir_y <= -19'sd65536;
            r_pln_x <= 19'sd43253;
            r_pln_y <= 19'sd0;
            r_tex_w <= 9'd64;
            r_tex_h <= 9'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POS_X: r_pos_x <= i_cfg_data;
                REG_POS_Y: r_pos_y <= i_cfg_data;
                REG_DIR_X: r_dir_x <= i_cfg_data[18:0];
                REG_DIR_Y: r_dir_y <= i_cfg_data[18:0];
                REG_PLN_X: r_pln_x <= i_cfg_data[18:0];
                REG_PLN_Y: r_pln_y <= i_cfg_data[18:0];
                REG_TEX_W: r_tex_w <= i_cfg_data[8:0];
                REG_TEX_H: r_tex_h <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Captured input word.
    logic              r_op;
    logic [5:0]        r_cx, r_cy;
    logic signed [17:0] r_cam;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_cx   <= i_cell_x;
            r_cy   <= i_cell_y;
            r_cam  <= i_camera_offset;
        end
    end

    // Map memory: one write port, one registered read port.
    logic              mem [MAP_DEPTH];
    logic              r_map_q;
    logic [5:0]        r_wx, r_wy;
    logic [MAP_AW-1:0] n_raddr;

    assign n_raddr = {r_wy, r_wx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_opcode == OP_WRITE)
            mem[{i_cell_y, i_cell_x}] <= i_cell_is_wall;
        r_map_q <= mem[n_raddr];
    end

    // Ray direction: dir + floor(plane * cam >> F).
    logic signed [36:0] n_px, n_py;
    logic signed [20:0] r_rdx, r_rdy;
    assign n_px = r_pln_x * r_cam;
    assign n_py = r_pln_y * r_cam;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ray) begin
            r_rdx <= 21'(r_dir_x) + 21'(n_px >>> FRAC_BITS);
            r_rdy <= 21'(r_dir_y) + 21'(n_py >>> FRAC_BITS);
        end
    end

    // Shared divider.
    logic [63:0] n_num, div_q;
    logic [31:0] n_den;
    logic        div_done;
    logic [20:0] n_adx, n_ady;
    logic [31:0] r_dx, r_dy, r_perp;
    logic [15:0] r_h;
    logic [23:0] r_ts;
    logic [8:0]  n_tw, n_th;

    assign n_adx = r_rdx[20] ? -r_rdx : r_rdx;
    assign n_ady = r_rdy[20] ? -r_rdy : r_rdy;
    assign n_tw  = (r_tex_w == 9'd0) ? 9'd1 : (r_tex_w > 9'd256 ? 9'd256 : r_tex_w);
    assign n_th  = (r_tex_h == 9'd0) ? 9'd1 : (r_tex_h > 9'd256 ? 9'd256 : r_tex_h);

    always_comb begin
        n_num = 64'd1 << (2 * FRAC_BITS);
        n_den = 32'(n_adx);
        case (i_cmd.div_sel)
            DIV_DX: begin
                n_num = 64'd1 << (2 * FRAC_BITS);
                n_den = 32'(n_adx);
            end
            DIV_DY: begin
                n_num = 64'd1 << (2 * FRAC_BITS);
                n_den = 32'(n_ady);
            end
            DIV_H: begin
                n_num = 64'(SCREEN_HEIGHT) << FRAC_BITS;
                n_den = r_perp;
            end
            DIV_TS: begin
                n_num = 64'(n_th) << FRAC_BITS;
                n_den = 32'(r_h);
            end
            default: ;
        endcase
    end

    ddar_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (n_num),
        .i_den   (n_den),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    // Side distances.
    logic [31:0] r_sx, r_sy;
    logic [22:0] n_ox, n_oy;
    logic signed [23:0] n_dfx, n_dfy;
    logic signed [56:0] n_mx, n_my;
    logic [22:0] n_cxq, n_cyq;

    assign n_cxq = {1'b0, r_cx, 16'd0};
    assign n_cyq = {1'b0, r_cy, 16'd0};
    assign n_dfx = r_rdx[20] ? ($signed({2'b0, r_pos_x}) - $signed({1'b0, n_cxq}))
                             : ($signed({1'b0, n_cxq}) + 24'sd65536 - $signed({2'b0, r_pos_x}));
    assign n_dfy = r_rdy[20] ? ($signed({2'b0, r_pos_y}) - $signed({1'b0, n_cyq}))
                             : ($signed({1'b0, n_cyq}) + 24'sd65536 - $signed({2'b0, r_pos_y}));
    assign n_mx  = n_dfx * $signed({1'b0, r_dx});
    assign n_my  = n_dfy * $signed({1'b0, r_dy});

    function automatic logic [31:0] sat_s(input logic signed [56:0] v);
        logic signed [40:0] s;
        s = 41'(v >>> FRAC_BITS);
        if (s < 0) return 32'd0;
        if (s > $signed({9'd0, MAX32})) return MAX32;
        return s[31:0];
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? MAX32 : s[31:0];
    endfunction

    // DDA walk.
    logic   r_ew;
    logic   n_gox;
    logic   n_edge;
    assign n_gox  = r_sx < r_sy;
    assign n_edge = n_gox ? (r_rdx[20] ? (r_wx == 6'd0) : (r_wx == 6'(MAP_SIZE - 1)))
                          : (r_rdy[20] ? (r_wy == 6'd0) : (r_wy == 6'(MAP_SIZE - 1)));

    logic [STEP_W-1:0] r_steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dx <= '0; r_dy <= '0; r_sx <= '0; r_sy <= '0;
            r_wx <= '0; r_wy <= '0; r_ew <= 1'b0; r_steps <= '0;
        end else begin
            if (i_cmd.div_take && i_cmd.div_sel == DIV_DX)
                r_dx <= (n_adx == 21'd0 || div_q > 64'(MAX32)) ? MAX32 : div_q[31:0];
            if (i_cmd.div_take && i_cmd.div_sel == DIV_DY)
                r_dy <= (n_ady == 21'd0 || div_q > 64'(MAX32)) ? MAX32 : div_q[31:0];
            if (i_cmd.side_mul) begin
                r_sx <= sat_s(n_mx);
                r_sy <= sat_s(n_my);
                r_wx <= r_cx;
                r_wy <= r_cy;
                r_steps <= '0;
            end
            if (i_cmd.walk_step) begin
                r_steps <= r_steps + 1'b1;
                if (!n_edge) begin
                    if (n_gox) begin
                        r_wx <= r_rdx[20] ? r_wx - 6'd1 : r_wx + 6'd1;
                        r_sx <= sat_add(r_sx, r_dx);
                        r_ew <= 1'b1;
                    end else begin
                        r_wy <= r_rdy[20] ? r_wy - 6'd1 : r_wy + 6'd1;
                        r_sy <= sat_add(r_sy, r_dy);
                        r_ew <= 1'b0;
                    end
                end
            end
        end
    end

    // Edge seen at a step ends the walk; remember it for the controller.
    logic r_exit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_exit <= 1'b0;
        else if (i_cmd.side_mul)
            r_exit <= 1'b0;
        else if (i_cmd.walk_step && n_edge)
            r_exit <= 1'b1;
    end

    // Column results.
    logic [1:0]  r_face;
    logic [21:0] n_base;
    logic signed [20:0] n_rd;
    logic signed [53:0] n_wm;
    logic [15:0] r_frac;
    logic [9:0]  r_ds, r_de;
    logic [7:0]  r_tx;
    logic [14:0] n_half;
    logic [31:0] n_side, n_del;
    logic [16:0] n_txp;
    logic [24:0] n_tsf;

    assign n_side = r_ew ? r_sx : r_sy;
    assign n_del  = r_ew ? r_dx : r_dy;
    assign n_base = r_ew ? r_pos_y : r_pos_x;
    assign n_rd   = r_ew ? r_rdy : r_rdx;
    assign n_wm   = $signed({1'b0, r_perp}) * n_rd;
    assign n_half = r_h[15:1];
    assign n_txp  = 17'((25'(r_frac) * 25'(n_tw)) >> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_perp) begin
            r_perp <= (n_side == MAX32) ? MAX32 : (n_side >= n_del ? n_side - n_del : 32'd0);
            r_face <= r_ew ? (r_rdx[20] ? 2'd3 : 2'd2) : (r_rdy[20] ? 2'd0 : 2'd1);
        end
        if (i_cmd.div_take && i_cmd.div_sel == DIV_H)
            r_h <= (r_perp == 32'd0 || div_q > 64'(MAX16)) ? MAX16 : div_q[15:0];
        if (i_cmd.div_take && i_cmd.div_sel == DIV_TS)
            r_ts <= (r_h == 16'd0 || div_q > 64'(MAX24)) ? MAX24 : div_q[23:0];
        if (i_cmd.fin_wall)
            r_frac <= 16'(22'(n_base) + 22'(n_wm >>> FRAC_BITS));
        if (i_cmd.fin_tex) begin
            r_tx <= (r_face == 2'd3 || r_face == 2'd1)
                    ? 8'(9'(n_tw) - 9'(n_txp) - 9'd1) : 8'(n_txp);
            r_ds <= (16'(n_half) >= 16'(SCREEN_HEIGHT / 2)) ? 10'd0
                    : 10'(16'(SCREEN_HEIGHT / 2) - 16'(n_half));
            r_de <= (16'(n_half) + 16'(SCREEN_HEIGHT / 2) >= 16'(SCREEN_HEIGHT))
                    ? 10'(SCREEN_HEIGHT - 1) : 10'(16'(n_half) + 16'(SCREEN_HEIGHT / 2));
        end
    end

    // Texture start: (ds - scr/2 + half) * step; the factor is zero unless
    // draw start was clamped to row zero.
    logic [15:0] n_k;
    logic [39:0] n_tp;
    assign n_k  = 16'(r_ds) + 16'(n_half) - 16'(SCREEN_HEIGHT / 2);
    assign n_tp = 40'(n_k) * 40'(r_ts);
    assign n_tsf = 25'(r_ts);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_nohit) begin
                o_perp_distance <= '0; o_hit_face <= '0; o_hit_cell_x <= '0;
                o_hit_cell_y <= '0; o_line_height <= '0; o_draw_start <= '0;
                o_draw_end <= '0; o_tex_column <= '0; o_tex_step <= '0;
                o_tex_start_pos <= '0; o_no_hit <= 1'b1;
            end else begin
                o_perp_distance <= r_perp;
                o_hit_face      <= r_face;
                o_hit_cell_x    <= r_wx;
                o_hit_cell_y    <= r_wy;
                o_line_height   <= r_h;
                o_draw_start    <= r_ds;
                o_draw_end      <= r_de;
                o_tex_column    <= r_tx;
                o_tex_step      <= n_tsf[23:0];
                o_tex_start_pos <= (n_tp > 40'(MAX24)) ? MAX24 : n_tp[23:0];
                o_no_hit        <= 1'b0;
            end
        end
    end

    assign o_sts.is_write   = (r_op == OP_WRITE);
    assign o_sts.div_done   = div_done;
    assign o_sts.walk_hit   = r_map_q;
    assign o_sts.walk_exit  = r_exit;
    assign o_sts.steps_done = (r_steps == STEP_W'(MAX_STEPS));
endmodule

[src/ddar_ctrl.sv]
// Controller: sequences ray setup, the DDA walk, divisions and result hand-off.
module ddar_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  ddar_pkg::t_sts i_sts,
    output ddar_pkg::t_cmd o_cmd
);
    import ddar_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_DEC   = 14'b00000000000010,
        S_RAY   = 14'b00000000000100,
        S_DX    = 14'b00000000001000,
        S_DY    = 14'b00000000010000,
        S_SIDE  = 14'b00000000100000,
        S_STEP  = 14'b00000001000000,
        S_RD    = 14'b00000010000000,
        S_TEST  = 14'b00000100000000,
        S_PERP  = 14'b00001000000000,
        S_H     = 14'b00010000000000,
        S_TS    = 14'b00100000000000,
        S_FIN   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   r_started, n_started;
    logic   r_nohit, n_nohit;
    logic   r_fin2, n_fin2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= 1'b0; r_started <= 1'b0;
            r_nohit <= 1'b0;   r_fin2 <= 1'b0;
        end else begin
            r_state <= n_state; r_valid <= n_valid; r_started <= n_started;
            r_nohit <= n_nohit; r_fin2 <= n_fin2;
        end
    end

    always_comb begin
        n_state = r_state; n_started = r_started; n_nohit = r_nohit; n_fin2 = r_fin2;
        n_valid = r_valid && i_stall;
        o_cmd = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: n_state = i_sts.is_write ? S_IDLE : S_RAY;
            S_RAY: begin
                o_cmd.ray = 1'b1; n_state = S_DX; n_started = 1'b0;
            end
            S_DX, S_DY, S_H, S_TS: begin
                o_cmd.div_sel = (r_state == S_DX) ? DIV_DX : (r_state == S_DY) ? DIV_DY
                              : (r_state == S_H) ? DIV_H : DIV_TS;
                if (!r_started) begin
                    o_cmd.div_start = 1'b1; n_started = 1'b1;
                end else if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1; n_started = 1'b0;
                    n_state = (r_state == S_DX) ? S_DY : (r_state == S_DY) ? S_SIDE
                            : (r_state == S_H) ? S_TS : S_FIN;
                end
            end
            S_SIDE: begin
                o_cmd.side_mul = 1'b1; n_state = S_STEP;
            end
            S_STEP: begin
                if (i_sts.steps_done) begin
                    n_nohit = 1'b1; n_state = S_OUT;
                end else begin
                    o_cmd.walk_step = 1'b1; n_state = S_RD;
                end
            end
            S_RD: begin
                if (i_sts.walk_exit) begin
                    n_nohit = 1'b1; n_state = S_OUT;
                end else n_state = S_TEST;
            end
            S_TEST: n_state = i_sts.walk_hit ? S_PERP : S_STEP;
            S_PERP: begin
                o_cmd.fin_perp = 1'b1; n_nohit = 1'b0; n_state = S_H;
            end
            S_FIN: begin
                if (!r_fin2) begin
                    o_cmd.fin_wall = 1'b1; n_fin2 = 1'b1;
                end else begin
                    o_cmd.fin_tex = 1'b1; n_fin2 = 1'b0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold the result until the previous word leaves
                if (!(r_valid && i_stall)) begin
                    o_cmd.out_load = 1'b1; o_cmd.out_nohit = r_nohit;
                    n_valid = 1'b1; n_nohit = 1'b0; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid = r_valid;
endmodule

[src/dda_grid_raycaster.sv]
// Top level: DDA grid raycaster producing one wall column word per cast.
//
//  channel | valid    | stall    | payload
//  in      | i_valid  | o_stall  | i_opcode, i_cell_x/y, i_cell_is_wall, i_camera_offset
//  out     | o_valid  | i_stall  | o_perp_distance ... o_no_hit
//  config  | i_cfg_we | (none)   | i_cfg_index, i_cfg_data
//
// A map write passes from idle through decode and back. A cast runs four divisions
// (one quotient bit per cycle in the shared divider) and up to 130 DDA steps,
// each a step, a map read and a test, between setup and finish.
// Reset is synchronous, active low; map contents are undefined until written.
// A finished word waits in the output register; a new input word is taken
// once the controller returns to idle.
module dda_grid_raycaster (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [5:0]         i_cell_x,
    input  logic [5:0]         i_cell_y,
    input  logic               i_cell_is_wall,
    input  logic signed [17:0] i_camera_offset,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_perp_distance,
    output logic [1:0]         o_hit_face,
    output logic [5:0]         o_hit_cell_x,
    output logic [5:0]         o_hit_cell_y,
    output logic [15:0]        o_line_height,
    output logic [9:0]         o_draw_start,
    output logic [9:0]         o_draw_end,
    output logic [7:0]         o_tex_column,
    output logic [23:0]        o_tex_step,
    output logic [23:0]        o_tex_start_pos,
    output logic               o_no_hit,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [21:0]        i_cfg_data
);
    import ddar_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ddar_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ddar_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_cell_is_wall  (i_cell_is_wall),
        .i_camera_offset (i_camera_offset),
        .o_perp_distance (o_perp_distance),
        .o_hit_face      (o_hit_face),
        .o_hit_cell_x    (o_hit_cell_x),
        .o_hit_cell_y    (o_hit_cell_y),
        .o_line_height   (o_line_height),
        .o_draw_start    (o_draw_start),
        .o_draw_end      (o_draw_end),
        .o_tex_column    (o_tex_column),
        .o_tex_step      (o_tex_step),
        .o_tex_start_pos (o_tex_start_pos),
        .o_no_hit        (o_no_hit)
    );
endmodule

[test/dda_grid_raycaster_test.sv]
// Testbench for the DDA grid raycaster: self-checking, with a directed table and random casts.
`timescale 1ns / 100ps

module dda_grid_raycaster_test;
    import ddar_pkg::*;

    localparam int  CLK_HALF    = 5;
    localparam int  CYCLE_LIMIT = 6_000_000;
    localparam int  PHASES      = 9;
    localparam int  PHASE_WORDS = 105;
    localparam longint ONE      = 64'd1 << FRAC_BITS;

    // Face codes as the block reports them.
    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_SOUTH = 2'd1;
    localparam logic [1:0] FACE_EAST  = 2'd2;
    localparam logic [1:0] FACE_WEST  = 2'd3;

    typedef struct packed {
        logic [31:0] perp;
        logic [1:0]  face;
        logic [5:0]  hx;
        logic [5:0]  hy;
        logic [15:0] height;
        logic [9:0]  row_start;
        logic [9:0]  row_end;
        logic [7:0]  tex_col;
        logic [23:0] tex_stp;
        logic [23:0] tex_pos;
        logic        miss;
    } t_column;

    // One row of the directed table; a typed column is used when fixed is set.
    typedef struct {
        logic        op;
        logic [5:0]  x;
        logic [5:0]  y;
        logic        wall;
        int          cam;
        logic        fixed;
        t_column     col;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_opcode = OP_WRITE;
    logic [5:0]         i_cell_x = '0;
    logic [5:0]         i_cell_y = '0;
    logic               i_cell_is_wall = 1'b0;
    logic signed [17:0] i_camera_offset = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [31:0]        o_perp_distance;
    logic [1:0]         o_hit_face;
    logic [5:0]         o_hit_cell_x;
    logic [5:0]         o_hit_cell_y;
    logic [15:0]        o_line_height;
    logic [9:0]         o_draw_start;
    logic [9:0]         o_draw_end;
    logic [7:0]         o_tex_column;
    logic [23:0]        o_tex_step;
    logic [23:0]        o_tex_start_pos;
    logic               o_no_hit;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = REG_POS_X;
    logic [21:0]        i_cfg_data = '0;

    dda_grid_raycaster dut (.*);

    always #CLK_HALF i_clk = ~i_clk;

    // Mirror of the block: wall grid and register file.
    logic        wall_map [MAP_DEPTH];
    logic [21:0] view_regs [8];
    t_column     column_q [$];
    t_stim_row   table_rows [$];
    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    bit          idle_on = 1'b1;
    int          stall_left = 0;

    function automatic longint sat32(longint v);
        if (v < 0) return 0;
        if (v > longint'(MAX32)) return longint'(MAX32);
        return v;
    endfunction

    function automatic longint inv_mag(longint d);
        longint a;
        longint q;
        if (d == 0) return longint'(MAX32);
        a = (d < 0) ? -d : d;
        q = (64'd1 << (2 * FRAC_BITS)) / a;
        return (q > longint'(MAX32)) ? longint'(MAX32) : q;
    endfunction

    function automatic longint tex_clamp(logic [8:0] v);
        if (v == 0) return 1;
        return (v > 256) ? 256 : longint'(v);
    endfunction

    // Work out the wall column for one cast from the mirrored state.
    function automatic t_column trace_column(logic [5:0] cx, logic [5:0] cy,
                                             logic [17:0] cam_raw);
        t_column c;
        longint cam, px, py, rdx, rdy, dlx, dly, sdx, sdy;
        longint side, del, perp, h, half, ds, de, wh, frac, tw, th, tx, tstp, tpos;
        int     wx, wy;
        bit     hit, ew;
        c   = '0;
        cam = longint'($signed(cam_raw));
        px  = longint'(view_regs[REG_POS_X]);
        py  = longint'(view_regs[REG_POS_Y]);
        rdx = longint'($signed(view_regs[REG_DIR_X][18:0]))
            + ((longint'($signed(view_regs[REG_PLN_X][18:0])) * cam) >>> FRAC_BITS);
        rdy = longint'($signed(view_regs[REG_DIR_Y][18:0]))
            + ((longint'($signed(view_regs[REG_PLN_Y][18:0])) * cam) >>> FRAC_BITS);
        dlx = inv_mag(rdx);
        dly = inv_mag(rdy);
        if (rdx < 0) sdx = sat32(((px - longint'(cx) * ONE) * dlx) >>> FRAC_BITS);
        else         sdx = sat32(((longint'(cx) * ONE + ONE - px) * dlx) >>> FRAC_BITS);
        if (rdy < 0) sdy = sat32(((py - longint'(cy) * ONE) * dly) >>> FRAC_BITS);
        else         sdy = sat32(((longint'(cy) * ONE + ONE - py) * dly) >>> FRAC_BITS);
        wx  = int'(cx);
        wy  = int'(cy);
        hit = 1'b0;
        ew  = 1'b0;
        // Skip the start cell; test each entered cell, stop at the grid edge.
        for (int i = 0; i < MAX_STEPS && !hit; i++) begin
            if (sdx < sdy) begin
                if (rdx < 0 ? wx == 0 : wx >= MAP_SIZE - 1) break;
                wx  = (rdx < 0) ? wx - 1 : wx + 1;
                sdx = (sdx + dlx > longint'(MAX32)) ? longint'(MAX32) : sdx + dlx;
                ew  = 1'b1;
            end else begin
                if (rdy < 0 ? wy == 0 : wy >= MAP_SIZE - 1) break;
                wy  = (rdy < 0) ? wy - 1 : wy + 1;
                sdy = (sdy + dly > longint'(MAX32)) ? longint'(MAX32) : sdy + dly;
                ew  = 1'b0;
            end
            if (wall_map[wy * MAP_SIZE + wx]) hit = 1'b1;
        end
        if (!hit) begin
            c.miss = 1'b1;
            return c;
        end
        side = ew ? sdx : sdy;
        del  = ew ? dlx : dly;
        perp = (side == longint'(MAX32)) ? side : ((side >= del) ? side - del : 0);
        if (ew) c.face = (rdx < 0) ? FACE_WEST : FACE_EAST;
        else    c.face = (rdy < 0) ? FACE_NORTH : FACE_SOUTH;
        if (perp == 0) h = 65535;
        else begin
            h = (longint'(SCREEN_HEIGHT) << FRAC_BITS) / perp;
            if (h > 65535) h = 65535;
        end
        half = h / 2;
        ds = SCREEN_HEIGHT / 2 - half;
        if (ds < 0) ds = 0;
        de = SCREEN_HEIGHT / 2 + half;
        if (de >= SCREEN_HEIGHT) de = SCREEN_HEIGHT - 1;
        if (ew) wh = py + ((perp * rdy) >>> FRAC_BITS);
        else    wh = px + ((perp * rdx) >>> FRAC_BITS);
        frac = wh & (ONE - 1);
        tw = tex_clamp(view_regs[REG_TEX_W][8:0]);
        th = tex_clamp(view_regs[REG_TEX_H][8:0]);
        tx = (frac * tw) >>> FRAC_BITS;
        if (c.face == FACE_WEST || c.face == FACE_SOUTH) tx = tw - tx - 1;
        if (h == 0) tstp = longint'(MAX24);
        else begin
            tstp = (th << FRAC_BITS) / h;
            if (tstp > longint'(MAX24)) tstp = longint'(MAX24);
        end
        tpos = (ds - SCREEN_HEIGHT / 2 + half) * tstp;
        if (tpos > longint'(MAX24)) tpos = longint'(MAX24);
        c.perp      = perp[31:0];
        c.hx        = wx[5:0];
        c.hy        = wy[5:0];
        c.height    = h[15:0];
        c.row_start = ds[9:0];
        c.row_end   = de[9:0];
        c.tex_col   = tx[7:0];
        c.tex_stp   = tstp[23:0];
        c.tex_pos   = tpos[23:0];
        return c;
    endfunction

    // Present one input word, with an optional gap first; hold it until taken.
    task automatic send_word(logic op, logic [5:0] x, logic [5:0] y, logic wall,
                             logic [17:0] cam, logic fixed, t_column col);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_cell_x        <= x;
        i_cell_y        <= y;
        i_cell_is_wall  <= wall;
        i_camera_offset <= cam;
        do @(posedge i_clk); while (o_stall);
        if (op == OP_WRITE) wall_map[y * MAP_SIZE + x] = wall;
        else column_q.push_back(fixed ? col : trace_column(x, y, cam));
    endtask

    // Write one register once the block has drained.
    task automatic write_reg(logic [2:0] idx, logic [21:0] val);
        i_valid <= 1'b0;
        wait (column_q.size() == 0);
        repeat (16) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        view_regs[idx] = (idx < REG_DIR_X) ? val : (idx < REG_TEX_W) ? {3'b0, val[18:0]}
                                                                     : {13'b0, val[8:0]};
    endtask

    function automatic logic [17:0] rand_cam();
        if ($urandom_range(0, 9) == 0) return 18'($urandom);
        return 18'(int'($urandom_range(0, 131072)) - 65536);
    endfunction

    function automatic logic [21:0] rand_vec(logic [2:0] idx);
        if ($urandom_range(0, 7) == 0) return 22'($urandom);
        if (idx < REG_DIR_X) return 22'($urandom_range(1 << 16, 63 << 16));
        if (idx < REG_TEX_W) return 22'(int'($urandom_range(0, 262144)) - 131072);
        return 22'($urandom_range(1, 256));
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // Receiver: random stall bursts; no new burst starts when idling is off.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 11);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Compare each accepted column word against the oldest expectation.
    always @(posedge i_clk) begin
        t_column want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (column_q.size() == 0) begin
                $display("%0t: unexpected column word, expected none, actual perp %0h",
                         $time, o_perp_distance);
                fail_cnt++;
            end else begin
                want = column_q.pop_front();
                check_field("perp_distance", want.perp, o_perp_distance);
                check_field("hit_face", want.face, o_hit_face);
                check_field("hit_cell_x", want.hx, o_hit_cell_x);
                check_field("hit_cell_y", want.hy, o_hit_cell_y);
                check_field("line_height", want.height, o_line_height);
                check_field("draw_start", want.row_start, o_draw_start);
                check_field("draw_end", want.row_end, o_draw_end);
                check_field("tex_column", want.tex_col, o_tex_column);
                check_field("tex_step", want.tex_stp, o_tex_step);
                check_field("tex_start_pos", want.tex_pos, o_tex_start_pos);
                check_field("no_hit", want.miss, o_no_hit);
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void add_row(logic op, int x, int y, logic wall, int cam,
                                    logic fixed);
        t_stim_row r;
        r.op = op; r.x = x[5:0]; r.y = y[5:0]; r.wall = wall; r.cam = cam;
        r.fixed = fixed;
        r.col = '0;
        r.col.miss = 1'b1;
        table_rows.push_back(r);
    endfunction

    initial begin
        t_column   none;
        t_stim_row r;
        none = '0;
        view_regs[REG_POS_X] = 22'd2129920;
        view_regs[REG_POS_Y] = 22'd2129920;
        view_regs[REG_DIR_X] = 22'd0;
        view_regs[REG_DIR_Y] = {3'b0, 19'h70000};
        view_regs[REG_PLN_X] = 22'd43253;
        view_regs[REG_PLN_Y] = 22'd0;
        view_regs[REG_TEX_W] = 22'd64;
        view_regs[REG_TEX_H] = 22'd64;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Clear the grid so no cast ever reads an unwritten cell.
        for (int c = 0; c < MAP_DEPTH; c++)
            send_word(OP_WRITE, 6'(c % MAP_SIZE), 6'(c / MAP_SIZE), 1'b0, '0, 1'b0, none);

        // Directed: empty grid misses, then wall hits, corners, edges.
        add_row(OP_CAST, 32, 32, 0, 0, 1);
        add_row(OP_CAST, 32, 32, 0, -65536, 1);
        add_row(OP_CAST, 32, 32, 0, 65536, 1);
        add_row(OP_CAST, 0, 0, 0, 0, 1);
        add_row(OP_CAST, 63, 63, 0, 131071, 0);
        add_row(OP_WRITE, 32, 31, 1, 0, 0);
        add_row(OP_CAST, 32, 32, 0, 0, 0);
        add_row(OP_WRITE, 32, 31, 0, 0, 0);
        add_row(OP_WRITE, 32, 0, 1, 0, 0);
        add_row(OP_CAST, 32, 32, 0, 0, 0);
        add_row(OP_WRITE, 31, 32, 1, 0, 0);
        add_row(OP_WRITE, 33, 32, 1, 0, 0);
        add_row(OP_WRITE, 32, 33, 1, 0, 0);
        add_row(OP_CAST, 32, 32, 0, -65536, 0);
        add_row(OP_CAST, 32, 32, 0, 65536, 0);
        add_row(OP_CAST, 32, 34, 0, -131072, 0);
        add_row(OP_WRITE, 63, 63, 1, 0, 0);
        add_row(OP_WRITE, 0, 0, 1, 0, 0);
        add_row(OP_CAST, 63, 62, 0, 0, 0);
        add_row(OP_CAST, 0, 5, 0, 65535, 0);
        add_row(OP_CAST, 63, 0, 0, -1, 0);
        foreach (table_rows[i]) begin
            r = table_rows[i];
            send_word(r.op, r.x, r.y, r.wall, 18'(r.cam), r.fixed, r.col);
        end

        for (int p = 0; p < PHASES; p++) begin
            // Extremes in the first phases, random settings after.
            for (int k = 0; k < 8; k++) begin
                case (p)
                    0: write_reg(3'(k), (k < 2) ? 22'h3FFFFF : (k < 6) ? 22'h020000 : 22'd256);
                    1: write_reg(3'(k), (k < 2) ? 22'd0 : (k < 6) ? 22'h3E0000 : 22'd1);
                    2: write_reg(3'(k), (k < 6) ? 22'($urandom) : 22'($urandom_range(0, 511)));
                    default: write_reg(3'(k), rand_vec(3'(k)));
                endcase
            end
            if (p == PHASES - 1) idle_on = 1'b0;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 4) == 0)
                    send_word(OP_WRITE, 6'($urandom), 6'($urandom),
                              ($urandom_range(0, 99) < 60), rand_cam(), 1'b0, none);
                else
                    send_word(OP_CAST, 6'($urandom), 6'($urandom), 1'($urandom),
                              rand_cam(), 1'b0, none);
            end
        end
        i_valid <= 1'b0;

        wait (column_q.size() == 0);
        repeat (700) @(posedge i_clk);
        if (fail_cnt == 0 && column_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[files.f]
src/ddar_pkg.sv
src/ddar_divider.sv
src/ddar_datapath.sv
src/ddar_ctrl.sv
src/dda_grid_raycaster.sv
test/dda_grid_raycaster_test.sv
